// File: src/ett_pkg.sv
// types and constants shared by the expiring id table
`timescale 1ns / 1ps
`default_nettype none

package ett_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_PRUNE  = 2'd2
  } opcode_e;

  localparam logic [31:0] LifetimeReset = 32'd30000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [7:0]  op_family;
    logic [63:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] hit_family;
  } out_word_t;

  typedef struct packed {
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [7:0]  family;
    logic [63:0] expiry;
  } slot_t;

  localparam int unsigned SlotWidth = $bits(slot_t);

endpackage

`default_nettype wire

// File: src/ett_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module ett_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AddrWidth-1:0]  waddr_i,
  input  wire logic [Width-1:0]      wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AddrWidth-1:0]  raddr_i,
  output logic      [Width-1:0]      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/expiring_id_tombstone_table_core.sv
// expiring id table: slot memory scan for insert, lookup and prune
//
//   channel  signals                          direction
//   in       in_valid_i / in_stall_o / in_word_i    into the block
//   out      out_valid_o / out_stall_i / out_word_o out of the block
//   cfg      cfg_we_i / cfg_wdata_i (lifetime_ms)   into the block
//
// a word is handled in steps: ST_IDLE takes the word, then in ST_SCAN the single
// read port of the slot memory walks every slot, one a cycle, then ST_LAST compares
// the last slot and ST_FIN writes back and loads the result register.
// reset clears the valid bits at once; slot memory contents are not cleared.
// a new word is taken while the previous result waits on out_stall_i; its
// write back then holds until the result register is free.
`timescale 1ns / 1ps
`default_nettype none

module expiring_id_tombstone_table_core
  import ett_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o,
  input  wire logic      cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int unsigned IdxWidth = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]         life_q;
  logic [SLOTS-1:0]    valid_q;
  logic [IdxWidth-1:0] cnt_q;
  logic                pv_q;
  logic [IdxWidth-1:0] pidx_q;

  logic [1:0]          op_q;
  logic [63:0]         idh_q, idl_q, now_q, exp_q;
  logic [7:0]          fam_in_q;
  logic                ovf_q;

  logic                found_q;
  logic [7:0]          hit_q;
  logic                free_q;
  logic [IdxWidth-1:0] free_idx_q;
  logic                best_have_q;
  logic [IdxWidth-1:0] best_idx_q;
  logic [63:0]         best_exp_q;

  logic                out_valid_q;
  out_word_t           out_word_q;

  slot_t               rd_slot;
  logic [SlotWidth-1:0] rd_data;
  slot_t               wr_slot;
  logic                in_acc;
  logic                slot_vld;
  logic                id_match;
  logic                out_free;
  logic                commit;
  logic                do_write;
  logic [IdxWidth-1:0] wr_idx;
  logic [64:0]         exp_sum;
  out_word_t           res;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !(out_valid_q && out_stall_i);
  assign commit    = (state_q == ST_FIN) && out_free;
  assign do_write  = commit && (op_q == OP_INSERT) && !ovf_q;
  assign wr_idx    = free_q ? free_idx_q : best_idx_q;
  assign exp_sum   = {1'b0, in_word_i.now_ms} + {33'b0, life_q};
  assign rd_slot   = slot_t'(rd_data);
  assign slot_vld  = valid_q[pidx_q];
  assign id_match  = (rd_slot.id_high == idh_q) && (rd_slot.id_low == idl_q);

  always_comb begin
    wr_slot.id_high = idh_q;
    wr_slot.id_low  = idl_q;
    wr_slot.family  = fam_in_q;
    wr_slot.expiry  = exp_q;
  end

  always_comb begin
    res.ok         = 1'b0;
    res.hit_family = 8'd0;
    unique case (op_q)
      OP_INSERT: res.ok = !ovf_q;
      OP_LOOKUP: begin
        res.ok         = found_q;
        res.hit_family = found_q ? hit_q : 8'd0;
      end
      OP_PRUNE:  res.ok = 1'b1;
      default:   res.ok = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (cnt_q == LastIdx) state_d = ST_LAST;
      ST_LAST: state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  ett_ram #(
    .Width(SlotWidth),
    .Depth(SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (wr_idx),
    .wdata_i (SlotWidth'(wr_slot)),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (cnt_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      life_q      <= LifetimeReset;
      valid_q     <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      pidx_q      <= '0;
      found_q     <= 1'b0;
      hit_q       <= 8'd0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      best_have_q <= 1'b0;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        life_q <= cfg_wdata_i;
      end
      pv_q   <= (state_q == ST_SCAN);
      pidx_q <= cnt_q;
      if (in_acc) begin
        cnt_q       <= '0;
        found_q     <= 1'b0;
        hit_q       <= 8'd0;
        free_q      <= 1'b0;
        best_have_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
      end
      // slot compare, one slot a cycle, in the cycle after its read
      if (pv_q) begin
        unique case (op_q)
          OP_INSERT: begin
            if (!free_q) begin
              if (!slot_vld) begin
                free_q     <= 1'b1;
                free_idx_q <= pidx_q;
              end else if (!best_have_q || (rd_slot.expiry < best_exp_q)) begin
                best_have_q <= 1'b1;
                best_idx_q  <= pidx_q;
              end
            end
          end
          OP_LOOKUP: begin
            if (!found_q && slot_vld && id_match) begin
              found_q <= 1'b1;
              hit_q   <= rd_slot.family;
            end
          end
          OP_PRUNE: begin
            if (slot_vld && (now_q >= rd_slot.expiry)) begin
              valid_q[pidx_q] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (do_write) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= in_word_i.opcode;
      idh_q    <= in_word_i.id_high;
      idl_q    <= in_word_i.id_low;
      fam_in_q <= in_word_i.op_family;
      now_q    <= in_word_i.now_ms;
      exp_q    <= exp_sum[63:0];
      ovf_q    <= exp_sum[64];
    end
    if (pv_q && (op_q == OP_INSERT) && !free_q && slot_vld &&
        (!best_have_q || (rd_slot.expiry < best_exp_q))) begin
      best_exp_q <= rd_slot.expiry;
    end
    if (commit) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// File: src/ett_checker.sv
// port checker for the expiring id table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ett_checker
  import ett_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("input taken again too early");

  a_miss_family_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.ok |-> out_word_o.hit_family == 8'd0)
    else $error("family set on a failed word");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result with no word in progress");

endmodule

bind expiring_id_tombstone_table_core ett_checker u_ett_checker (.*);

`default_nettype wire

// File: dv/expiring_id_tombstone_table_core_tb.sv
// testbench for the expiring id table: predicts every result word and checks it in order
`timescale 1ns / 1ps

module expiring_id_tombstone_table_core_tb;
  import ett_pkg::*;

  localparam int unsigned Slots = 16;
  localparam int unsigned Latency = Slots + 3;
  localparam int unsigned PoolSize = 24;
  localparam int unsigned Phases = 6;
  localparam int unsigned PhaseItems = 258;
  localparam int unsigned LongHold = 400;
  localparam int unsigned IdleLimit = 2000;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [63:0] TimeMax = 64'hFFFF_FFFF_FFFF_FFFF;

  class id_table_checker;
    bit          slot_used[Slots];
    logic [63:0] slot_hi[Slots];
    logic [63:0] slot_lo[Slots];
    logic [7:0]  slot_fam[Slots];
    logic [63:0] slot_exp[Slots];
    logic [31:0] lifetime;
    out_word_t   expected_results[$];
    int          mismatches;

    function new();
      lifetime = LifetimeReset;
      mismatches = 0;
      for (int i = 0; i < Slots; i++) begin
        slot_used[i] = 1'b0;
        slot_hi[i] = '0;
        slot_lo[i] = '0;
        slot_fam[i] = '0;
        slot_exp[i] = '0;
      end
    endfunction

    function void set_lifetime(logic [31:0] v);
      lifetime = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function out_word_t predict_result(in_word_t w);
      out_word_t   r;
      logic [64:0] sum;
      int          victim;
      r = '0;
      case (w.opcode)
        OP_INSERT: begin
          sum = {1'b0, w.now_ms} + {33'd0, lifetime};
          if (!sum[64]) begin
            victim = -1;
            for (int i = 0; i < Slots; i++) begin
              if (!slot_used[i]) begin
                victim = i;
                break;
              end
            end
            if (victim < 0) begin
              victim = 0;
              for (int i = 1; i < Slots; i++) begin
                if (slot_exp[i] < slot_exp[victim]) victim = i;
              end
            end
            slot_used[victim] = 1'b1;
            slot_hi[victim] = w.id_high;
            slot_lo[victim] = w.id_low;
            slot_fam[victim] = w.op_family;
            slot_exp[victim] = sum[63:0];
            r.ok = 1'b1;
          end
        end
        OP_LOOKUP: begin
          for (int i = 0; i < Slots; i++) begin
            if (slot_used[i] && slot_hi[i] == w.id_high && slot_lo[i] == w.id_low) begin
              r.ok = 1'b1;
              r.hit_family = slot_fam[i];
              break;
            end
          end
        end
        OP_PRUNE: begin
          for (int i = 0; i < Slots; i++) begin
            if (slot_used[i] && w.now_ms >= slot_exp[i]) begin
              slot_used[i] = 1'b0;
              slot_hi[i] = '0;
              slot_lo[i] = '0;
              slot_fam[i] = '0;
              slot_exp[i] = '0;
            end
          end
          r.ok = 1'b1;
        end
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_word(in_word_t w);
      expected_results.push_back(predict_result(w));
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing expected: ok=%0b hit_family=%0h",
                   $realtime, got.ok, got.hit_family);
        return;
      end
      want = expected_results.pop_front();
      if (got.ok !== want.ok || got.hit_family !== want.hit_family) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: ok exp %0b got %0b, hit_family exp %0h got %0h",
                   $realtime, want.ok, got.ok, want.hit_family, got.hit_family);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  id_table_checker table_sb = new();

  logic [127:0] id_pool[PoolSize];
  logic [63:0]  cur_now = '0;
  logic [31:0]  cur_life = LifetimeReset;
  int unsigned  adv_max = 1;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;
  bit           long_hold_req = 1'b0;
  int unsigned  idle_cycles = 0;

  expiring_id_tombstone_table_core #(
    .SLOTS(Slots)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, logic [127:0] id, logic [7:0] fam,
                                         logic [63:0] now);
    in_word_t w;
    w.opcode = op;
    {w.id_high, w.id_low} = id;
    w.op_family = fam;
    w.now_ms = now;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       roll;
    roll = $urandom_range(0, 99);
    w.op_family = 8'($urandom_range(0, 255));
    if (roll < 12) begin
      w.opcode = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 0) begin
        {w.id_high, w.id_low} = id_pool[$urandom_range(0, PoolSize - 1)];
      end else begin
        w.id_high = rand64();
        w.id_low = rand64();
      end
      w.now_ms = rand64();
      return w;
    end
    {w.id_high, w.id_low} = id_pool[$urandom_range(0, PoolSize - 1)];
    cur_now = cur_now + $urandom_range(0, adv_max);
    w.now_ms = cur_now;
    roll = $urandom_range(0, 99);
    if (roll < 45) w.opcode = OP_INSERT;
    else if (roll < 82) w.opcode = OP_LOOKUP;
    else w.opcode = OP_PRUNE;
    if (w.opcode == OP_INSERT && $urandom_range(0, 30) == 0)
      w.now_ms = TimeMax - {32'd0, cur_life} - 64'd2 + $urandom_range(0, 4);
    return w;
  endfunction

  // caller sits at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input in_word_t w);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    table_sb.note_word(w);
  endtask

  task automatic write_lifetime(input logic [31:0] v);
    in_valid <= 1'b0;
    while (table_sb.pending() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    table_sb.set_lifetime(v);
    cur_life = v;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) table_sb.check_word(out_word);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("expiring_id_tombstone_table_core_tb: FAIL");
      $finish;
    end
  end

  initial begin : receiver
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      n = recv_burst ? 0 : $urandom_range(0, 10);
      if (long_hold_req) begin
        n = LongHold;
        long_hold_req = 1'b0;
      end
      if (n == 0) out_stall <= 1'b0;
      else begin
        out_stall <= 1'b1;
        do @(posedge clk_i); while (!out_valid);
        repeat (n - 1) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    logic [127:0] id_x;
    logic [127:0] id_y;
    logic [31:0]  next_life;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) id_pool[i] = {rand64(), rand64()};
    id_x = {rand64(), rand64()};
    id_y = {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, duplicates, overflow, unused opcode, prune boundary
    send_word(make_word(OP_LOOKUP, '0, 8'h00, 64'd0));
    send_word(make_word(OP_INSERT, '0, 8'h00, 64'd0));
    send_word(make_word(OP_INSERT, '1, 8'hFF, 64'd5));
    send_word(make_word(OP_LOOKUP, '1, 8'h00, 64'd0));
    send_word(make_word(OP_LOOKUP, '0, 8'hFF, TimeMax));
    send_word(make_word(OP_INSERT, '1, 8'h5A, 64'd10));
    send_word(make_word(OP_LOOKUP, '1, 8'h00, 64'd0));
    send_word(make_word(OP_INSERT, id_x, 8'h3C, TimeMax));
    send_word(make_word(OP_INSERT, id_x, 8'hC3, TimeMax - {32'd0, LifetimeReset}));
    send_word(make_word(OP_LOOKUP, id_x, 8'h00, 64'd0));
    send_word(make_word(OpUnused, id_x, 8'hFF, TimeMax));
    send_word(make_word(OP_PRUNE, '0, 8'h00, 64'd29999));
    send_word(make_word(OP_LOOKUP, '0, 8'h00, 64'd0));
    send_word(make_word(OP_PRUNE, '1, 8'hFF, 64'd30000));
    send_word(make_word(OP_LOOKUP, '0, 8'h00, 64'd0));
    send_word(make_word(OP_INSERT, id_y, 8'hA5, 64'd100));
    send_word(make_word(OP_LOOKUP, id_y, 8'h00, 64'd0));
    send_word(make_word(OP_PRUNE, '0, 8'h00, TimeMax));
    send_word(make_word(OP_LOOKUP, id_x, 8'h00, 64'd0));
    send_word(make_word(OP_LOOKUP, '1, 8'h00, 64'd0));

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: next_life = LifetimeReset;
        1: next_life = 32'd0;
        2: next_life = 32'hFFFF_FFFF;
        3: next_life = 32'd1;
        4: next_life = $urandom_range(20, 2000);
        default: next_life = LifetimeReset;
      endcase
      if (p != 0) write_lifetime(next_life);
      adv_max = (next_life / 40 > 1) ? next_life / 40 : 1;
      cur_now = rand64() >> $urandom_range(20, 63);
      send_burst = (p == 1);
      recv_burst = (p == 1);
      if (p == 3) long_hold_req = 1'b1;
      for (int k = 0; k < PhaseItems; k++) send_word(random_word());
    end

    in_valid <= 1'b0;
    while (table_sb.pending() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
    if (table_sb.mismatches == 0 && table_sb.pending() == 0)
      $display("expiring_id_tombstone_table_core_tb: PASS");
    else
      $display("expiring_id_tombstone_table_core_tb: FAIL");
    $finish;
  end

endmodule
